[src/gmi_pkg.sv]
// ----------------------------------------------------------------------------
// gmi_pkg
// shared types, constants and helpers of the grid interpolator
// ----------------------------------------------------------------------------
package gmi_pkg;

    localparam int DIMS        = 2;
    localparam int ACTIONS     = 2;
    localparam int GRID_MAX    = 16;
    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = 8;
    localparam int DATA_W      = 32;
    localparam int PTS_W       = 5;
    localparam int CELL_W      = 4;
    localparam int FRAC_W      = 17;
    localparam int QUOT_W      = 20;
    localparam int NUM_W       = 36;
    localparam int CFG_IDX_W   = 3;
    localparam int CORNERS     = 4;
    localparam int ACC_W       = 52;
    localparam int ENTRY_W     = DATA_W * (1 + ACTIONS);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOW0  = 3'd0,
        CFG_HIGH0 = 3'd1,
        CFG_LOW1  = 3'd2,
        CFG_HIGH1 = 3'd3,
        CFG_PTS0  = 3'd4,
        CFG_PTS1  = 3'd5
    } t_cfg_idx;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_QUERY = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_CELL,
        ST_MAC,
        ST_FIN
    } t_state;

    // point count limited to 2..GRID_MAX
    function automatic logic [PTS_W-1:0] eff_points(input logic [PTS_W-1:0] n);
        logic [PTS_W-1:0] r;
        r = n;
        if (n < PTS_W'(2)) r = PTS_W'(2);
        if (n > PTS_W'(GRID_MAX)) r = PTS_W'(GRID_MAX);
        return r;
    endfunction

endpackage

[src/gmi_if.sv]
// ----------------------------------------------------------------------------
// gmi channel interfaces
// query/write input, result output and configuration write channels
// ----------------------------------------------------------------------------
interface gmi_in_if;
    import gmi_pkg::*;
    logic                     valid;
    logic                     ready;
    logic                     command;
    logic [ADDR_W-1:0]        entry_index;
    logic signed [DATA_W-1:0] entry_value;
    logic signed [DATA_W-1:0] entry_action0;
    logic signed [DATA_W-1:0] entry_action1;
    logic signed [DATA_W-1:0] query_coord0;
    logic signed [DATA_W-1:0] query_coord1;
    modport source (output valid, command, entry_index, entry_value, entry_action0,
                    entry_action1, query_coord0, query_coord1, input ready);
    modport sink   (input valid, command, entry_index, entry_value, entry_action0,
                    entry_action1, query_coord0, query_coord1, output ready);
endinterface

interface gmi_out_if;
    import gmi_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] blended_value;
    logic signed [DATA_W-1:0] blended_action0;
    logic signed [DATA_W-1:0] blended_action1;
    modport source (output valid, blended_value, blended_action0, blended_action1,
                    input ready);
    modport sink   (input valid, blended_value, blended_action0, blended_action1,
                    output ready);
endinterface

interface gmi_cfg_if;
    import gmi_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DATA_W-1:0]    data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[src/grid_multilinear_interpolator.sv]
// ----------------------------------------------------------------------------
// grid_multilinear_interpolator
// bilinear blend of value and action entries over a configurable 2-d grid
// ----------------------------------------------------------------------------
//  channel   dir   handshake      payload
//  i_in      in    valid/ready    command, entry index, entry data, query point
//  o_out     out   valid/ready    blended value, blended action0/1
//  i_cfg     in    valid/ready    register index, write data (always ready)
//
//  a table write is stored at its transfer; a query runs from transfer to
//  result through clamp, bit-serial grid scaling (20 quotient bits), cell
//  select, then four corner reads from the single-port entry memory with a
//  multiply-accumulate
//  no memory clearing after reset; registers reset to a unit box, 16 points
//  the result register lets the next item in while a result waits on o_out
// ----------------------------------------------------------------------------
module grid_multilinear_interpolator
    import gmi_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    gmi_in_if.sink   i_in,
    gmi_out_if.source o_out,
    gmi_cfg_if.sink  i_cfg
);

    // configuration
    logic signed [DATA_W-1:0] r_lo  [DIMS];
    logic signed [DATA_W-1:0] r_hi  [DIMS];
    logic [PTS_W-1:0]         r_pts [DIMS];

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int d = 0; d < DIMS; d++) begin
                r_lo[d]  <= '0;
                r_hi[d]  <= DATA_W'(32'h0001_0000);
                r_pts[d] <= PTS_W'(GRID_MAX);
            end
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_LOW0:  r_lo[0]  <= i_cfg.data;
                CFG_HIGH0: r_hi[0]  <= i_cfg.data;
                CFG_LOW1:  r_lo[1]  <= i_cfg.data;
                CFG_HIGH1: r_hi[1]  <= i_cfg.data;
                CFG_PTS0:  r_pts[0] <= i_cfg.data[PTS_W-1:0];
                CFG_PTS1:  r_pts[1] <= i_cfg.data[PTS_W-1:0];
                default: ;
            endcase
        end
    end

    // control
    t_state r_state, n_state;
    logic [2:0] r_corner;
    logic       in_xfer, out_free;
    logic       div_start, div_done;

    assign i_in.ready = (r_state == ST_IDLE);
    assign in_xfer    = i_in.valid && i_in.ready;
    assign out_free   = !o_out.valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        case (r_state)
            ST_IDLE: if (in_xfer && i_in.command == CMD_QUERY) n_state = ST_PREP;
            ST_PREP: begin
                div_start = 1'b1;
                n_state   = ST_DIV;
            end
            ST_DIV:  if (div_done) n_state = ST_CELL;
            ST_CELL: n_state = ST_MAC;
            ST_MAC:  if (r_corner == 3'(CORNERS)) n_state = ST_FIN;
            ST_FIN:  if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // query point capture
    logic signed [DATA_W-1:0] r_x [DIMS];
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_x[0] <= i_in.query_coord0;
            r_x[1] <= i_in.query_coord1;
        end
    end

    // per-dimension clamp, span and scaled distance, then divide
    logic [DATA_W-1:0] r_span [DIMS];
    logic              r_en   [DIMS];
    logic [QUOT_W-1:0] quot   [DIMS];
    logic              done_d [DIMS];
    logic [PTS_W-1:0]  npts   [DIMS];

    for (genvar d = 0; d < DIMS; d++) begin : g_dim
        logic signed [DATA_W-1:0] xc;
        logic [DATA_W-1:0]        x_off;
        logic [NUM_W-1:0]         num;
        always_comb begin
            npts[d] = eff_points(r_pts[d]);
            xc      = r_x[d];
            if (xc < r_lo[d]) xc = r_lo[d];
            if (xc > r_hi[d]) xc = r_hi[d];
            x_off   = DATA_W'(xc - r_lo[d]);
            // sampled by the divider on its start cycle
            num     = NUM_W'(x_off) * NUM_W'(npts[d] - 1'b1);
        end
        always_ff @(posedge i_clk) begin
            if (r_state == ST_PREP) begin
                r_span[d] <= DATA_W'(r_hi[d] - r_lo[d]);
                r_en[d]   <= r_hi[d] > r_lo[d];
            end
        end
        gmi_div u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (div_start),
            .i_num   (num),
            .i_span  (r_span[d]),
            .o_done  (done_d[d]),
            .o_quot  (quot[d])
        );
    end

    assign div_done = done_d[0] && done_d[1];

    // cell index and fraction, empty box gives cell 0, fraction 0
    logic [CELL_W-1:0] r_cell [DIMS];
    logic [FRAC_W-1:0] r_frac [DIMS];
    always_ff @(posedge i_clk) begin
        if (r_state == ST_CELL) begin
            for (int d = 0; d < DIMS; d++) begin
                logic [QUOT_W-1:0] t;
                logic [CELL_W-1:0] ci;
                logic [CELL_W-1:0] cmax;
                t    = r_en[d] ? quot[d] : '0;
                cmax = CELL_W'(npts[d] - PTS_W'(2));
                ci   = t[QUOT_W-1:16];
                if (ci > cmax) ci = cmax;
                r_cell[d] <= ci;
                r_frac[d] <= FRAC_W'(t - {ci, 16'h0000});
            end
        end
    end

    // corner walk: address and weight for corner k, data of k-1 arrives
    logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
    logic [ENTRY_W-1:0] r_rdata;
    logic [FRAC_W-1:0]  r_w;
    logic               r_mv;
    logic [ADDR_W-1:0]  rd_addr;
    logic [FRAC_W-1:0]  wd0, wd1;
    logic [2*FRAC_W-1:0] wprod;
    logic               issue;

    assign issue = (r_state == ST_MAC) && (r_corner < 3'(CORNERS));

    always_comb begin
        logic [CELL_W:0] idx0, idx1;
        idx0    = {1'b0, r_cell[0]} + (CELL_W+1)'(r_corner[0]);
        idx1    = {1'b0, r_cell[1]} + (CELL_W+1)'(r_corner[1]);
        rd_addr = ADDR_W'(idx0) + ADDR_W'(idx1 * npts[0]);
        wd0     = r_corner[0] ? r_frac[0] : FRAC_W'(17'h10000 - r_frac[0]);
        wd1     = r_corner[1] ? r_frac[1] : FRAC_W'(17'h10000 - r_frac[1]);
        wprod   = wd0 * wd1;
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && i_in.command == CMD_WRITE) begin
            mem[i_in.entry_index] <= {i_in.entry_action1, i_in.entry_action0,
                                      i_in.entry_value};
        end
        if (issue) r_rdata <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_corner <= '0;
            r_mv     <= 1'b0;
        end else begin
            r_mv <= issue;
            if (r_state == ST_MAC) r_corner <= r_corner + 1'b1;
            else                   r_corner <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) r_w <= wprod[FRAC_W+15:16];
    end

    // accumulate w * entry for value and both actions
    logic signed [ACC_W-1:0] r_acc [1+ACTIONS];
    always_ff @(posedge i_clk) begin
        if (r_state == ST_CELL) begin
            for (int k = 0; k < 1 + ACTIONS; k++) r_acc[k] <= '0;
        end else if (r_mv) begin
            for (int k = 0; k < 1 + ACTIONS; k++) begin
                r_acc[k] <= r_acc[k] + ACC_W'($signed({1'b0, r_w})
                            * $signed(r_rdata[k*DATA_W +: DATA_W]));
            end
        end
    end

    // floor by 2^16 with saturation into the result register
    logic signed [DATA_W-1:0] res [1+ACTIONS];
    always_comb begin
        for (int k = 0; k < 1 + ACTIONS; k++) begin
            logic signed [ACC_W-17:0] s;
            s = r_acc[k][ACC_W-1:16];
            if (s > $signed((ACC_W-16)'(33'sh0_7FFF_FFFF)))
                res[k] = 32'sh7FFF_FFFF;
            else if (s < -$signed((ACC_W-16)'(33'sh0_8000_0000)))
                res[k] = 32'sh8000_0000;
            else
                res[k] = s[DATA_W-1:0];
        end
    end

    logic r_ovalid;
    logic signed [DATA_W-1:0] r_res [1+ACTIONS];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == ST_FIN && out_free) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_FIN && out_free) begin
            for (int k = 0; k < 1 + ACTIONS; k++) r_res[k] <= res[k];
        end
    end

    assign o_out.valid           = r_ovalid;
    assign o_out.blended_value   = r_res[0];
    assign o_out.blended_action0 = r_res[1];
    assign o_out.blended_action1 = r_res[2];

endmodule

[src/gmi_div.sv]
// ----------------------------------------------------------------------------
// gmi_div
// restoring divider, one quotient bit per cycle, (num << 16) / span
// ----------------------------------------------------------------------------
module gmi_div
    import gmi_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DATA_W-1:0] i_span,
    output logic              o_done,
    output logic [QUOT_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(QUOT_W + 1);

    logic [DATA_W-1:0] r_rem;
    logic [QUOT_W-1:0] r_low;
    logic [QUOT_W-1:0] r_quot;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic [DATA_W:0]   n_trial;
    logic              n_ge;

    assign n_trial = {r_rem, r_low[QUOT_W-1]};
    assign n_ge    = n_trial >= {1'b0, i_span};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(QUOT_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            // quotient fits in QUOT_W bits, so the top part is below span
            r_rem  <= i_num[NUM_W-1:NUM_W-DATA_W];
            r_low  <= {i_num[NUM_W-DATA_W-1:0], (QUOT_W-(NUM_W-DATA_W))'(0)};
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= n_ge ? DATA_W'(n_trial - {1'b0, i_span}) : n_trial[DATA_W-1:0];
            r_low  <= {r_low[QUOT_W-2:0], 1'b0};
            r_quot <= {r_quot[QUOT_W-2:0], n_ge};
        end
    end

    assign o_done = !r_busy;
    assign o_quot = r_quot;

endmodule

[tb/tb_grid_multilinear_interpolator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grid_multilinear_interpolator
// self-checking bench: preloads the entry table, walks a directed table of
// writes and queries, then runs randomized phases under several grid settings
// with random idling on both channels; every result is compared field by field
// against its typed-in result or a bit-accurate bilinear predictor in the bench
// ----------------------------------------------------------------------------
module tb_grid_multilinear_interpolator;
    import gmi_pkg::*;

    localparam int WATCHDOG_LIMIT = 6000;   // cycles with no transfer at all
    localparam int SETTLE_CYCLES  = 40;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 125;
    localparam int PRESSURE_HOLD  = 400;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] action0;
        logic signed [DATA_W-1:0] action1;
    } blend_t;

    typedef struct {
        t_cmd                     cmd;
        logic [ADDR_W-1:0]        index;
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] action0;
        logic signed [DATA_W-1:0] action1;
        logic signed [DATA_W-1:0] coord0;
        logic signed [DATA_W-1:0] coord1;
        bit                       typed;     // expected result typed in below
        blend_t                   typed_res;
    } item_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    gmi_in_if  in_if();
    gmi_out_if out_if();
    gmi_cfg_if cfg_if();

    grid_multilinear_interpolator u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    always #5 i_clk = ~i_clk;

    // bench copy of the grid registers and the entry table
    logic signed [DATA_W-1:0] grid_low [DIMS];
    logic signed [DATA_W-1:0] grid_high[DIMS];
    logic [PTS_W-1:0]         grid_pts [DIMS];
    logic signed [DATA_W-1:0] tbl_value  [TABLE_DEPTH];
    logic signed [DATA_W-1:0] tbl_action0[TABLE_DEPTH];
    logic signed [DATA_W-1:0] tbl_action1[TABLE_DEPTH];

    blend_t pending_blends[$];

    int  error_count   = 0;
    int  queries_done  = 0;
    int  writes_done   = 0;
    int  cfg_writes    = 0;
    int  idle_cycles   = 0;
    bit  no_idle       = 0;
    bit  pressure_req  = 0;
    bit  pressure_seen = 0;

    function automatic int usable_points(logic [PTS_W-1:0] n);
        int r;
        r = n;
        if (r < 2) r = 2;
        if (r > GRID_MAX) r = GRID_MAX;
        return r;
    endfunction

    function automatic longint floor_sat(longint acc);
        longint r;
        r = acc >>> 16;
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return r;
    endfunction

    // bilinear blend of the four corners around the clamped point
    function automatic blend_t bilinear_blend(logic signed [DATA_W-1:0] c0,
                                              logic signed [DATA_W-1:0] c1);
        longint lo, hi, x, t, cell_i, w, wd, acc_v, acc_a0, acc_a1;
        longint cell_at[DIMS];
        longint frac[DIMS];
        int     n, addr, stride, idx;
        blend_t r;
        for (int d = 0; d < DIMS; d++) begin
            lo = grid_low[d];
            hi = grid_high[d];
            x  = (d == 0) ? longint'(c0) : longint'(c1);
            n  = usable_points(grid_pts[d]);
            t  = 0;
            if (x < lo) x = lo;
            if (x > hi) x = hi;
            if (hi > lo) t = (((x - lo) * (n - 1)) <<< 16) / (hi - lo);
            cell_i = t >>> 16;
            if (cell_i > n - 2) cell_i = n - 2;
            cell_at[d] = cell_i;
            frac[d] = t - (cell_i <<< 16);
        end
        acc_v = 0; acc_a0 = 0; acc_a1 = 0;
        for (int c = 0; c < CORNERS; c++) begin
            w = 65536; addr = 0; stride = 1;
            for (int d = 0; d < DIMS; d++) begin
                idx = int'(cell_at[d]);
                if ((c >> d) & 1) begin
                    idx += 1;
                    wd = frac[d];
                end else begin
                    wd = 65536 - frac[d];
                end
                w = (w * wd) >>> 16;
                addr += idx * stride;
                stride *= usable_points(grid_pts[d]);
            end
            addr &= TABLE_DEPTH - 1;
            acc_v  += w * longint'(tbl_value[addr]);
            acc_a0 += w * longint'(tbl_action0[addr]);
            acc_a1 += w * longint'(tbl_action1[addr]);
        end
        r.value   = DATA_W'(floor_sat(acc_v));
        r.action0 = DATA_W'(floor_sat(acc_a0));
        r.action1 = DATA_W'(floor_sat(acc_a1));
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
                                   logic [DATA_W-1:0] want);
        $display("[%0t] mismatch %s: got %h, expected %h", $realtime, what, got, want);
        error_count++;
    endtask

    // drive one item and wait for its transfer; valid stays high afterwards
    task automatic send_item(item_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid         <= 1'b1;
        in_if.command       <= it.cmd;
        in_if.entry_index   <= it.index;
        in_if.entry_value   <= it.value;
        in_if.entry_action0 <= it.action0;
        in_if.entry_action1 <= it.action1;
        in_if.query_coord0  <= it.coord0;
        in_if.query_coord1  <= it.coord1;
        do @(posedge i_clk); while (!in_if.ready);
        // transfer happened at this edge: update the bench model
        if (it.cmd == CMD_WRITE) begin
            tbl_value[it.index]   = it.value;
            tbl_action0[it.index] = it.action0;
            tbl_action1[it.index] = it.action1;
            writes_done++;
        end else if (it.typed) begin
            pending_blends.push_back(it.typed_res);
        end else begin
            pending_blends.push_back(bilinear_blend(it.coord0, it.coord1));
        end
    endtask

    // all results in and the pipeline drained; only then touch registers
    task automatic wait_idle();
        in_if.valid <= 1'b0;
        while (pending_blends.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_grid(logic signed [DATA_W-1:0] lo0, logic signed [DATA_W-1:0] hi0,
                              logic signed [DATA_W-1:0] lo1, logic signed [DATA_W-1:0] hi1,
                              logic [PTS_W-1:0] p0, logic [PTS_W-1:0] p1);
        logic [DATA_W-1:0] vals[6];
        t_cfg_idx          regs[6];
        vals = '{lo0, hi0, lo1, hi1, DATA_W'(p0), DATA_W'(p1)};
        regs = '{CFG_LOW0, CFG_HIGH0, CFG_LOW1, CFG_HIGH1, CFG_PTS0, CFG_PTS1};
        for (int k = 0; k < 6; k++) begin
            cfg_if.valid <= 1'b1;
            cfg_if.index <= regs[k];
            cfg_if.data  <= vals[k];
            do @(posedge i_clk); while (!cfg_if.ready);
            cfg_writes++;
        end
        cfg_if.valid <= 1'b0;
        grid_low[0] = lo0; grid_high[0] = hi0;
        grid_low[1] = lo1; grid_high[1] = hi1;
        grid_pts[0] = p0;  grid_pts[1] = p1;
    endtask

    function automatic logic signed [DATA_W-1:0] pick_coord(int d);
        longint lo, hi;
        lo = grid_low[d];
        hi = grid_high[d];
        case ($urandom_range(0, 7))
            0, 1, 2, 3, 4: begin
                if (hi > lo)
                    return DATA_W'(lo + longint'({$urandom, $urandom} % (hi - lo + 1)));
                return $urandom;
            end
            5:       return ($urandom_range(0, 1) != 0) ? grid_low[d] : grid_high[d];
            default: return $urandom;
        endcase
    endfunction

    function automatic item_t random_item();
        item_t it;
        it.cmd     = ($urandom_range(0, 99) < 30) ? CMD_WRITE : CMD_QUERY;
        it.index   = ADDR_W'($urandom);
        it.value   = $urandom;
        it.action0 = $urandom;
        it.action1 = $urandom;
        it.coord0  = pick_coord(0);
        it.coord1  = pick_coord(1);
        it.typed   = 0;
        it.typed_res = '0;
        return it;
    endfunction

    function automatic item_t make_item(t_cmd cmd, logic [ADDR_W-1:0] index,
                                        logic [DATA_W-1:0] v, logic [DATA_W-1:0] a0,
                                        logic [DATA_W-1:0] a1, logic [DATA_W-1:0] x0,
                                        logic [DATA_W-1:0] x1, bit typed,
                                        blend_t res);
        item_t it;
        it.cmd = cmd; it.index = index; it.value = v; it.action0 = a0; it.action1 = a1;
        it.coord0 = x0; it.coord1 = x1; it.typed = typed; it.typed_res = res;
        return it;
    endfunction

    // result side: random backpressure plus one long hold-off on request
    initial begin
        int stall_left;
        blend_t got, want;
        stall_left   = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_if.valid && out_if.ready) begin
                got = '{out_if.blended_value, out_if.blended_action0, out_if.blended_action1};
                if (pending_blends.size() == 0) begin
                    $display("[%0t] result with nothing pending", $realtime);
                    error_count++;
                end else begin
                    want = pending_blends.pop_front();
                    if (got.value !== want.value)
                        report_mismatch("blended_value", got.value, want.value);
                    if (got.action0 !== want.action0)
                        report_mismatch("blended_action0", got.action0, want.action0);
                    if (got.action1 !== want.action1)
                        report_mismatch("blended_action1", got.action1, want.action1);
                    queries_done++;
                end
            end
            if (pressure_req && !pressure_seen) begin
                pressure_seen = 1;
                stall_left    = PRESSURE_HOLD;
            end
            if (stall_left > 0) begin
                stall_left--;
                out_if.ready <= 1'b0;
            end else begin
                stall_left   = pick_gap();
                out_if.ready <= (stall_left == 0);
            end
        end
    end

    // watchdog on cycles with no transfer on any channel
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
                (cfg_if.valid && cfg_if.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", idle_cycles);
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        item_t  directed[$];
        item_t  it;
        blend_t r0, r255;
        logic signed [DATA_W-1:0] a, b, tmp;

        i_rst_n              <= 1'b0;
        in_if.valid          <= 1'b0;
        in_if.command        <= CMD_WRITE;
        in_if.entry_index    <= '0;
        in_if.entry_value    <= '0;
        in_if.entry_action0  <= '0;
        in_if.entry_action1  <= '0;
        in_if.query_coord0   <= '0;
        in_if.query_coord1   <= '0;
        cfg_if.valid         <= 1'b0;
        cfg_if.index         <= CFG_LOW0;
        cfg_if.data          <= '0;
        grid_low  = '{0, 0};
        grid_high = '{32'sd65536, 32'sd65536};
        grid_pts  = '{PTS_W'(GRID_MAX), PTS_W'(GRID_MAX)};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // preload every entry so no query ever reads an unwritten one
        no_idle = 1;
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            it = random_item();
            it.cmd   = CMD_WRITE;
            it.index = ADDR_W'(k);
            send_item(it);
        end
        no_idle = 0;

        // directed rows under the reset box: corners, clamps, upper edge
        r0   = '{32'sh7fffffff, 32'sh80000000, 32'sh00010000};
        r255 = '{32'sh80000000, 32'sh7fffffff, 32'shffffffff};
        directed.push_back(make_item(CMD_WRITE, 8'd0, r0.value, r0.action0, r0.action1,
                                     0, 0, 0, '0));
        directed.push_back(make_item(CMD_WRITE, 8'd255, r255.value, r255.action0,
                                     r255.action1, 0, 0, 0, '0));
        directed.push_back(make_item(CMD_QUERY, 8'd0, 0, 0, 0, 0, 0, 1, r0));
        directed.push_back(make_item(CMD_QUERY, 8'hff, 32'hffffffff, 32'hffffffff,
                                     32'hffffffff, 32'h7fffffff, 32'h7fffffff, 1, r255));
        directed.push_back(make_item(CMD_QUERY, 8'd0, 0, 0, 0, 32'h80000000,
                                     32'h80000000, 1, r0));
        directed.push_back(make_item(CMD_QUERY, 8'd0, 0, 0, 0, 32'h00010000, 0, 0, '0));
        directed.push_back(make_item(CMD_QUERY, 8'd0, 0, 0, 0, 0, 32'h00010000, 0, '0));
        directed.push_back(make_item(CMD_QUERY, 8'd0, 0, 0, 0, 32'h00008000,
                                     32'h00008000, 0, '0));
        directed.push_back(make_item(CMD_QUERY, 8'd0, 0, 0, 0, 32'd12345, 32'h0000ffff,
                                     0, '0));
        directed.push_back(make_item(CMD_WRITE, 8'd17, 32'h00020000, 32'hfffe0000,
                                     32'h00000001, 0, 0, 0, '0));
        directed.push_back(make_item(CMD_QUERY, 8'd0, 0, 0, 0, 32'h00001000,
                                     32'h00001000, 0, '0));
        directed.push_back(make_item(CMD_QUERY, 8'd0, 0, 0, 0, 32'hffffffff, 32'h00000001,
                                     0, '0));
        foreach (directed[k]) send_item(directed[k]);

        // random phases, each under its own grid setting
        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            case (p)
                0: write_grid(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                              5'd2, 5'd2);
                1: write_grid(-32'sd327680, 32'sd196608, 0, 32'sd65536, 5'd16, 5'd16);
                // empty box in dim 0, inverted box in dim 1, counts out of range
                2: write_grid(32'sd65536, 32'sd65536, 32'sd100, -32'sd100, 5'd0, 5'd31);
                3: write_grid(-32'sd65536, 32'sd65536, 32'sd1000, 32'sd900000, 5'd1, 5'd17);
                default: begin
                    a = $urandom; b = $urandom;
                    if (a > b) begin tmp = a; a = b; b = tmp; end
                    if (a == b) b = a + 1;
                    // low bound of dim 1 somewhere in -1000000..0
                    tmp = DATA_W'($urandom_range(0, 1000000));
                    tmp = -tmp;
                    write_grid(a, b, tmp, tmp + $urandom_range(1, 20000000),
                               PTS_W'($urandom_range(0, 31)), PTS_W'($urandom_range(2, 16)));
                end
            endcase
            no_idle = (p == 4);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (p == 1 && k == 10) pressure_req = 1;
                send_item(random_item());
            end
        end

        wait_idle();
        $display("covered %0d table writes, %0d checked queries, %0d register writes",
                 writes_done, queries_done, cfg_writes);
        $display("settings: unit box, full-range box, empty and inverted boxes, "
                 , "point counts out of range, random boxes");
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches", error_count);
            $display("Verification failed");
        end
        $finish;
    end

endmodule
